@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/ils_pkg.sv @@
// shared types and constants of the indexed list store
package ils_pkg;

    localparam int CAPACITY  = 256;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 9;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int GRP       = 16;
    localparam int NGRP      = (CAPACITY + GRP - 1) / GRP;
    localparam int S_FIELD_W = OP_W + POS_W + DATA_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = DATA_W + ST_W + POS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

@@ rtl/ils_cell.sv @@
// one list element: takes its value, its left or its right neighbor
module ils_cell (
    input  logic                          aclk,
    input  ils_pkg::cell_cmd_t            cmd,
    input  logic [ils_pkg::IDX_W-1:0]     cell_idx,
    input  logic [ils_pkg::DATA_W-1:0]    left_data,
    input  logic [ils_pkg::DATA_W-1:0]    right_data,
    output logic [ils_pkg::DATA_W-1:0]    data_out,
    output logic [ils_pkg::DATA_W-1:0]    rd_data
);
    import ils_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        priority if (cmd.ins && (cell_idx == cmd.pos)) begin
            data_next = cmd.value;
        end else if (cmd.ins && (cell_idx > cmd.pos)) begin
            data_next = left_data;
        end else if (cmd.del && (cell_idx >= cmd.pos)) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    // only the addressed cell drives the read tree
    assign rd_data  = (cell_idx == cmd.pos) ? data_reg : '0;

endmodule

@@ rtl/ils_chain.sv @@
// row of element cells with a two level read tree, registered at the group level
module ils_chain (
    input  logic                          aclk,
    input  ils_pkg::cell_cmd_t            cmd,
    input  logic                          grp_en,
    output logic [ils_pkg::DATA_W-1:0]    rd_word
);
    import ils_pkg::*;

    logic [DATA_W-1:0] cell_q  [CAPACITY];
    logic [DATA_W-1:0] rd_q    [NGRP*GRP];
    logic [DATA_W-1:0] grp_reg [NGRP];
    logic [DATA_W-1:0] grp_next[NGRP];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (i == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_mid_l
                assign left_d = cell_q[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_mid_r
                assign right_d = cell_q[i+1];
            end
            ils_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .cell_idx   (IDX_W'(i)),
                .left_data  (left_d),
                .right_data (right_d),
                .data_out   (cell_q[i]),
                .rd_data    (rd_q[i])
            );
        end
        for (i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
            assign rd_q[i] = '0;
        end
        for (i = 0; i < NGRP; i++) begin : g_grp
            always_comb begin
                grp_next[i] = '0;
                for (int j = 0; j < GRP; j++) begin
                    grp_next[i] = grp_next[i] | rd_q[i*GRP + j];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (grp_en) begin
            for (int g = 0; g < NGRP; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb begin
        rd_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            rd_word = rd_word | grp_reg[g];
        end
    end

endmodule

@@ rtl/indexed_list_store.sv @@
// indexed list store top level: request decode, length and result register
//
//  channel | dir | word contents (lsb first)
//  s_      | in  | operation[2:0], position[11:3], value[43:12]
//  m_      | out | read_value[31:0], status[33:32], length_now[42:34]
//
//  a request goes through accept, execute in the cell row, reduce the read tree
//  the reduce step serves the two level read tree, which is registered at the group level
//  a new request is taken while the previous word still waits on m_
//  reset clears the length and the handshake state, cell contents stay as they are
//  with m_tvalid high and m_tready low a finished request holds in the reduce step
`include "assert_macros.svh"
module indexed_list_store (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation, position, value
    input  logic [ils_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value, status, length_now
    output logic [ils_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ils_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ST_W-1:0]     st_reg, st_next;
    logic                hit_reg, hit_next;
    logic                miss_reg, miss_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    cell_cmd_t           cmd;
    logic [DATA_W-1:0]   rd_word;
    logic [CMP_W-1:0]    pos_ext, len_ext, ins_ext, len_after;
    logic [DATA_W-1:0]   rd_value;
    logic                out_free;

    assign pos_ext  = CMP_W'(pos_reg);
    assign len_ext  = CMP_W'(len_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (op_reg)
            OP_FRONT:  ins_ext = '0;
            OP_APPEND: ins_ext = len_ext;
            default:   ins_ext = pos_ext;
        endcase
    end

    // request decode, only in the execute step
    always_comb begin
        cmd       = '0;
        cmd.pos   = IDX_W'(ins_ext);
        cmd.value = val_reg;
        len_next  = len_reg;
        st_next   = st_reg;
        hit_next  = hit_reg;
        miss_next = miss_reg;
        if (state_reg == S_EXEC) begin
            st_next   = ST_DONE;
            hit_next  = 1'b0;
            miss_next = 1'b0;
            unique case (op_reg)
                OP_READ: begin
                    if (pos_ext < len_ext) begin
                        hit_next = 1'b1;
                    end else begin
                        miss_next = 1'b1;
                        st_next   = ST_RANGE;
                    end
                end
                OP_FRONT, OP_APPEND, OP_INSERT: begin
                    priority if (ins_ext > len_ext) begin
                        st_next = ST_RANGE;
                    end else if (len_ext >= CMP_W'(CAPACITY)) begin
                        st_next = ST_FULL;
                    end else begin
                        cmd.ins  = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                OP_DELETE: begin
                    if (pos_ext >= len_ext) begin
                        st_next = ST_RANGE;
                    end else begin
                        cmd.del  = 1'b1;
                        len_next = len_reg - LEN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (hit_reg) begin
            rd_value = rd_word;
        end else if (miss_reg) begin
            rd_value = '1;
        end else begin
            rd_value = '0;
        end
    end

    assign len_after = CMP_W'(len_reg);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[OP_W-1:0];
                    pos_next   = s_tdata[OP_W +: POS_W];
                    val_next   = s_tdata[OP_W+POS_W +: DATA_W];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_REDUCE;
            end
            S_REDUCE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({len_after[POS_W-1:0], st_reg, rd_value});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        st_reg      <= st_next;
        hit_reg     <= hit_next;
        miss_reg    <= miss_next;
        m_tdata_reg <= m_tdata_next;
    end

    ils_chain u_chain (
        .aclk    (aclk),
        .cmd     (cmd),
        .grp_en  (state_reg == S_EXEC),
        .rd_word (rd_word)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_ALWAYS(a_len_cap, aclk, aresetn, CMP_W'(len_reg) <= CMP_W'(CAPACITY))
    `ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_tvalid && s_tready, state_reg == S_EXEC)
    `ASSERT_NEXT(a_len_hold, aclk, aresetn, state_reg != S_EXEC, $stable(len_reg))
    `ASSERT_IMPL(a_full_len, aclk, aresetn, (state_reg == S_REDUCE) && (st_reg == ST_FULL), CMP_W'(len_reg) == CMP_W'(CAPACITY))
    `ASSERT_IMPL(a_hit_miss, aclk, aresetn, state_reg == S_REDUCE, !(hit_reg && miss_reg))

endmodule
